>>> hw/rtl/statement_end_scanner_assert.svh
// Assertion macros used by the scanner core of the statement end scanner RTL.
`ifndef STATEMENT_END_SCANNER_ASSERT_SVH
`define STATEMENT_END_SCANNER_ASSERT_SVH
`ifndef SYNTH
`define SESC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sesc assertion failed");
`define SESC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sesc forbidden condition seen");
`else
`define SESC_ASSERT(lbl, clk, rst_n, prop)
`define SESC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/sesc_pkg.sv
// Package with types, constants and the byte classifier of the statement end scanner.
`default_nettype none
package sesc_pkg;

  localparam int unsigned MAX_DEPTH       = 255;
  localparam int unsigned MAX_SCAN_LENGTH = 65536;
  localparam int unsigned DEPTH_W         = $clog2(MAX_DEPTH + 1);
  localparam int unsigned POS_W           = $clog2(MAX_SCAN_LENGTH + 1);
  localparam int unsigned BASE_W          = 24;
  localparam int unsigned END_W           = 25;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned OUT_DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

  typedef enum logic [3:0] {
    CC_OTHER,
    CC_SLASH,
    CC_STAR,
    CC_SQUOTE,
    CC_DQUOTE,
    CC_BSLASH,
    CC_SEMI,
    CC_LPAREN,
    CC_RPAREN,
    CC_LBRACK,
    CC_RBRACK,
    CC_LBRACE,
    CC_RBRACE,
    CC_NEWLINE
  } sesc_class_e;

  typedef enum logic [2:0] {
    MODE_CODE,
    MODE_LINE,
    MODE_BLOCK,
    MODE_SQUOTE,
    MODE_DQUOTE,
    MODE_DONE
  } sesc_mode_e;

  typedef struct packed {
    sesc_class_e cls;
    logic        last;
  } sesc_item_t;

  typedef struct packed {
    logic             found;
    logic [END_W-1:0] end_offset;
  } sesc_result_t;

  function automatic sesc_class_e classify(input logic [BYTE_W-1:0] b);
    sesc_class_e c;
    c = CC_OTHER;
    unique case (b)
      CH_SLASH:       c = CC_SLASH;
      CH_STAR:        c = CC_STAR;
      CH_SQUOTE:      c = CC_SQUOTE;
      CH_DQUOTE:      c = CC_DQUOTE;
      CH_BSLASH:      c = CC_BSLASH;
      CH_SEMI:        c = CC_SEMI;
      CH_LPAREN:      c = CC_LPAREN;
      CH_RPAREN:      c = CC_RPAREN;
      CH_LBRACK:      c = CC_LBRACK;
      CH_RBRACK:      c = CC_RBRACK;
      CH_LBRACE:      c = CC_LBRACE;
      CH_RBRACE:      c = CC_RBRACE;
      CH_LF, CH_CR:   c = CC_NEWLINE;
      default:        c = CC_OTHER;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sesc_front.sv
// Front stage: accepts source bytes and registers their character class.
`default_nettype none
module sesc_front
  import sesc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [BYTE_W-1:0]  in_byte_i,
  input  wire logic               in_last_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output sesc_item_t              out_item_o
);

  logic       valid_q, valid_d;
  sesc_item_t item_q, item_d;
  logic       take;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d     = 1'b1;
      item_d.cls  = classify(in_byte_i);
      item_d.last = in_last_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule
`default_nettype wire

>>> hw/rtl/sesc_queue.sv
// Short queue of classified items between the front and the scanner core.
`default_nettype none
module sesc_queue
  import sesc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_valid_i,
  output logic            push_ready_o,
  input  wire sesc_item_t push_item_i,
  output logic            pop_valid_o,
  input  wire logic       pop_ready_i,
  output sesc_item_t      pop_item_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  sesc_item_t       entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sesc_core.sv
// Scanner core: tracks comment, string and nesting state and registers one result per scan.
`default_nettype none
`include "statement_end_scanner_assert.svh"
module sesc_core
  import sesc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [BASE_W-1:0] base_offset_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sesc_item_t        in_item_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output sesc_result_t           res_o
);

  sesc_mode_e         mode_q, mode_d, step_mode;
  logic               esc_q, esc_d, step_esc;
  logic               slash_q, slash_d, step_slash;
  logic               star_q, star_d, step_star;
  logic [DEPTH_W-1:0] paren_q, paren_d, step_paren;
  logic [DEPTH_W-1:0] brack_q, brack_d, step_brack;
  logic [DEPTH_W-1:0] brace_q, brace_d, step_brace;
  logic [POS_W-1:0]   pos_q, pos_d, step_pos;
  logic               res_valid_q, res_valid_d;
  sesc_result_t       res_q, res_d;
  logic               out_free, pop, handled, term, active, at_top;
  sesc_class_e        cls;

  assign out_free   = !res_valid_q || res_ready_i;
  assign in_ready_o = !in_item_i.last || out_free;
  assign pop        = in_valid_i && in_ready_o;
  assign cls        = in_item_i.cls;
  assign active     = (mode_q != MODE_DONE) && (pos_q < POS_W'(MAX_SCAN_LENGTH));
  assign at_top     = (paren_q == '0) && (brack_q == '0) && (brace_q == '0);

  // Effect of one byte on the scan state.
  always_comb begin
    step_mode  = mode_q;
    step_esc   = esc_q;
    step_slash = slash_q;
    step_star  = star_q;
    step_paren = paren_q;
    step_brack = brack_q;
    step_brace = brace_q;
    step_pos   = pos_q;
    handled    = 1'b0;
    term       = 1'b0;
    if (active) begin
      unique case (mode_q)
        MODE_LINE: begin
          if (cls == CC_NEWLINE) begin
            step_mode = MODE_CODE;
          end
        end
        MODE_BLOCK: begin
          if (star_q && cls == CC_SLASH) begin
            step_mode = MODE_CODE;
            step_star = 1'b0;
          end else begin
            step_star = (cls == CC_STAR);
          end
        end
        MODE_SQUOTE, MODE_DQUOTE: begin
          if (esc_q) begin
            step_esc = 1'b0;
          end else if (cls == CC_BSLASH) begin
            step_esc = 1'b1;
          end else if ((mode_q == MODE_SQUOTE && cls == CC_SQUOTE) ||
                       (mode_q == MODE_DQUOTE && cls == CC_DQUOTE)) begin
            step_mode = MODE_CODE;
          end
        end
        MODE_CODE: begin
          if (slash_q) begin
            step_slash = 1'b0;
            if (cls == CC_SLASH) begin
              step_mode = MODE_LINE;
              handled   = 1'b1;
            end else if (cls == CC_STAR) begin
              step_mode = MODE_BLOCK;
              step_star = 1'b0;
              handled   = 1'b1;
            end
          end
          if (!handled) begin
            if (cls == CC_SLASH) begin
              step_slash = 1'b1;
            end else if (cls == CC_SQUOTE) begin
              step_mode = MODE_SQUOTE;
              step_esc  = 1'b0;
            end else if (cls == CC_DQUOTE) begin
              step_mode = MODE_DQUOTE;
              step_esc  = 1'b0;
            end else if ((cls == CC_SEMI || cls == CC_RBRACE) && at_top) begin
              term = 1'b1;
            end else if (cls == CC_LPAREN) begin
              if (paren_q < DEPTH_W'(MAX_DEPTH)) step_paren = paren_q + 1'b1;
            end else if (cls == CC_RPAREN) begin
              if (paren_q != '0) step_paren = paren_q - 1'b1;
            end else if (cls == CC_LBRACK) begin
              if (brack_q < DEPTH_W'(MAX_DEPTH)) step_brack = brack_q + 1'b1;
            end else if (cls == CC_RBRACK) begin
              if (brack_q != '0) step_brack = brack_q - 1'b1;
            end else if (cls == CC_LBRACE) begin
              if (brace_q < DEPTH_W'(MAX_DEPTH)) step_brace = brace_q + 1'b1;
            end else if (cls == CC_RBRACE) begin
              if (brace_q != '0) step_brace = brace_q - 1'b1;
            end
          end
        end
        default: begin
          step_mode = mode_q;
        end
      endcase
      if (term) begin
        step_mode = MODE_DONE;
      end else begin
        step_pos = pos_q + 1'b1;
      end
    end
  end

  // Next scan state: the stepped state, or a fresh scan after the last byte.
  always_comb begin
    mode_d  = mode_q;
    esc_d   = esc_q;
    slash_d = slash_q;
    star_d  = star_q;
    paren_d = paren_q;
    brack_d = brack_q;
    brace_d = brace_q;
    pos_d   = pos_q;
    if (pop) begin
      if (in_item_i.last) begin
        mode_d  = MODE_CODE;
        esc_d   = 1'b0;
        slash_d = 1'b0;
        star_d  = 1'b0;
        paren_d = '0;
        brack_d = '0;
        brace_d = '0;
        pos_d   = '0;
      end else begin
        mode_d  = step_mode;
        esc_d   = step_esc;
        slash_d = step_slash;
        star_d  = step_star;
        paren_d = step_paren;
        brack_d = step_brack;
        brace_d = step_brace;
        pos_d   = step_pos;
      end
    end
  end

  // Result register.
  always_comb begin
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
    if (pop && in_item_i.last) begin
      res_valid_d      = 1'b1;
      res_d.found      = (step_mode == MODE_DONE);
      res_d.end_offset = END_W'(base_offset_i) + END_W'(step_pos);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CODE;
      esc_q       <= 1'b0;
      slash_q     <= 1'b0;
      star_q      <= 1'b0;
      paren_q     <= '0;
      brack_q     <= '0;
      brace_q     <= '0;
      pos_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      esc_q       <= esc_d;
      slash_q     <= slash_d;
      star_q      <= star_d;
      paren_q     <= paren_d;
      brack_q     <= brack_d;
      brace_q     <= brace_d;
      pos_q       <= pos_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `SESC_ASSERT_NEVER(a_depth_bound, clk_i, rst_ni, (paren_q > DEPTH_W'(MAX_DEPTH)) || (brack_q > DEPTH_W'(MAX_DEPTH)) || (brace_q > DEPTH_W'(MAX_DEPTH)))
  `SESC_ASSERT_NEVER(a_pos_bound, clk_i, rst_ni, pos_q > POS_W'(MAX_SCAN_LENGTH))
  `SESC_ASSERT(a_clear_after_last, clk_i, rst_ni, (pop && in_item_i.last) |=> (mode_q == MODE_CODE && pos_q == '0 && paren_q == '0))
  `SESC_ASSERT(a_done_no_slash, clk_i, rst_ni, (mode_q == MODE_DONE) |-> !slash_q)

endmodule
`default_nettype wire

>>> hw/rtl/statement_end_scanner.sv
// Top level of the statement end scanner: front stage, item queue and scanner core.
//
// Source bytes enter on the s_axis channel, one byte per item, with tlast set on
// the final byte of a scan. One result leaves on m_axis for every scan: tuser
// says whether a top-level ';' or '}' ended the statement, and tdata holds the
// absolute offset of that terminator, or base offset plus scanned length.
// The base offset register is written through the cfg channel, which is always
// ready; the user must write it only while no scan is in progress, and the block
// itself does not enforce this. Throughput is one byte per cycle while the core
// is not held by a pending result at the last byte of a scan. After its last byte
// is accepted, a result passes the front stage register and a queue entry; the
// core loads the result register at the edge at which it takes that byte.
// Reset clears the scan state, the queue and the base offset, and drops any
// pending result. When the receiver stalls, the held result waits while bytes
// of the next scan keep flowing until that scan's last byte reaches the core;
// the four-entry queue and the front stage then fill before s_axis_tready falls.
`default_nettype none
module statement_end_scanner
  import sesc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] byte_value
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [24:0] end_offset, rest zero
  output logic                       m_axis_tuser,  // [0] found
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [BASE_W-1:0]     cfg_data_i
);

  logic [BASE_W-1:0] base_q;
  logic              front_valid, front_ready;
  sesc_item_t        front_item;
  logic              queue_valid, queue_ready;
  sesc_item_t        queue_item;
  sesc_result_t      result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_data_i;
    end
  end

  sesc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_item_o  (front_item)
  );

  sesc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_item_o   (queue_item)
  );

  sesc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .base_offset_i (base_q),
    .in_valid_i    (queue_valid),
    .in_ready_o    (queue_ready),
    .in_item_i     (queue_item),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_o         (result)
  );

  assign m_axis_tdata = OUT_DATA_W'(result.end_offset);
  assign m_axis_tuser = result.found;

endmodule
`default_nettype wire

>>> tb/statement_end_scanner_tb.sv
// Self-checking testbench for the statement end scanner with a built-in scan predictor.
module statement_end_scanner_tb;
  import sesc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              last;
  } src_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_valid = 1'b0;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_data = '0;
  logic                  s_last = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [BASE_W-1:0]     cfg_data = '0;

  src_byte_t    text_q[$];
  sesc_result_t scan_results[$];
  int unsigned  src_idle_pct = 0;
  int unsigned  snk_idle_pct = 0;
  int unsigned  n_pushed = 0;
  int unsigned  n_accepted = 0;
  int unsigned  n_errors = 0;
  int unsigned  cycles = 0;

  // Predictor state.
  logic [BASE_W-1:0]  scan_base = '0;
  sesc_mode_e         scan_state = MODE_CODE;
  logic               esc_p = 1'b0;
  logic               slash_p = 1'b0;
  logic               star_p = 1'b0;
  logic [DEPTH_W-1:0] paren_d = '0;
  logic [DEPTH_W-1:0] brack_d = '0;
  logic [DEPTH_W-1:0] brace_d = '0;
  logic [POS_W-1:0]   scan_pos = '0;

  string special_chars = "();[]{}/*'\"\\\n\015 a";

  statement_end_scanner u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit advance_scan(input logic [BYTE_W-1:0] c, input logic last,
                                      output sesc_result_t res);
    bit term;
    bit opened;
    term = 1'b0;
    opened = 1'b0;
    if (scan_state != MODE_DONE && scan_pos < MAX_SCAN_LENGTH) begin
      case (scan_state)
        MODE_LINE: begin
          if (c == CH_LF || c == CH_CR) scan_state = MODE_CODE;
        end
        MODE_BLOCK: begin
          if (star_p && c == CH_SLASH) begin
            scan_state = MODE_CODE;
            star_p = 1'b0;
          end else begin
            star_p = (c == CH_STAR);
          end
        end
        MODE_SQUOTE, MODE_DQUOTE: begin
          if (esc_p) begin
            esc_p = 1'b0;
          end else if (c == CH_BSLASH) begin
            esc_p = 1'b1;
          end else if ((scan_state == MODE_SQUOTE && c == CH_SQUOTE) ||
                       (scan_state == MODE_DQUOTE && c == CH_DQUOTE)) begin
            scan_state = MODE_CODE;
          end
        end
        default: begin
          if (slash_p) begin
            slash_p = 1'b0;
            if (c == CH_SLASH) begin
              scan_state = MODE_LINE;
              opened = 1'b1;
            end else if (c == CH_STAR) begin
              scan_state = MODE_BLOCK;
              star_p = 1'b0;
              opened = 1'b1;
            end
          end
          if (!opened) begin
            if (c == CH_SLASH) begin
              slash_p = 1'b1;
            end else if (c == CH_SQUOTE) begin
              scan_state = MODE_SQUOTE;
              esc_p = 1'b0;
            end else if (c == CH_DQUOTE) begin
              scan_state = MODE_DQUOTE;
              esc_p = 1'b0;
            end else if ((c == CH_SEMI || c == CH_RBRACE) && paren_d == 0 &&
                         brack_d == 0 && brace_d == 0) begin
              term = 1'b1;
            end else begin
              case (c)
                CH_LPAREN: if (paren_d < MAX_DEPTH) paren_d = paren_d + 1'b1;
                CH_RPAREN: if (paren_d > 0) paren_d = paren_d - 1'b1;
                CH_LBRACK: if (brack_d < MAX_DEPTH) brack_d = brack_d + 1'b1;
                CH_RBRACK: if (brack_d > 0) brack_d = brack_d - 1'b1;
                CH_LBRACE: if (brace_d < MAX_DEPTH) brace_d = brace_d + 1'b1;
                CH_RBRACE: if (brace_d > 0) brace_d = brace_d - 1'b1;
                default: ;
              endcase
            end
          end
        end
      endcase
      if (term) scan_state = MODE_DONE;
      else scan_pos = scan_pos + 1'b1;
    end
    res.found = (scan_state == MODE_DONE);
    res.end_offset = END_W'(scan_base) + END_W'(scan_pos);
    if (last) begin
      scan_state = MODE_CODE;
      esc_p = 1'b0;
      slash_p = 1'b0;
      star_p = 1'b0;
      paren_d = '0;
      brack_d = '0;
      brace_d = '0;
      scan_pos = '0;
    end
    return last;
  endfunction

  task automatic flag(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin : text_driver
    src_byte_t nb;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_axis_tready) begin
      if (text_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nb = text_q.pop_front();
        s_valid <= 1'b1;
        s_data <= nb.value;
        s_last <= nb.last;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    sesc_result_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready) begin
        n_accepted++;
        if (advance_scan(s_data, s_last, want)) scan_results.push_back(want);
      end
      if (m_axis_tvalid && m_ready) begin
        if (scan_results.size() == 0) begin
          flag($sformatf("result with none expected: found %0b end %0d",
                         m_axis_tuser, m_axis_tdata));
        end else begin
          want = scan_results.pop_front();
          if (m_axis_tuser !== want.found)
            flag($sformatf("found expected %0b actual %0b", want.found, m_axis_tuser));
          if (m_axis_tdata !== OUT_DATA_W'(want.end_offset))
            flag($sformatf("end_offset expected %0d actual %0d",
                           want.end_offset, m_axis_tdata));
        end
      end
      m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] value, input logic last);
    src_byte_t nb;
    nb.value = value;
    nb.last = last;
    text_q.push_back(nb);
    n_pushed++;
  endtask

  task automatic scan(input string body, input logic [BYTE_W-1:0] final_byte);
    for (int i = 0; i < body.len(); i++) push_byte(body[i], 1'b0);
    push_byte(final_byte, 1'b1);
  endtask

  function automatic logic [BYTE_W-1:0] noise_byte();
    if ($urandom_range(1)) return BYTE_W'($urandom_range(255));
    return special_chars[$urandom_range(special_chars.len() - 1)];
  endfunction

  function automatic logic [BYTE_W-1:0] letter();
    return BYTE_W'($urandom_range(8'h7A, 8'h61));
  endfunction

  task automatic gen_scan();
    logic [BYTE_W-1:0] closers[$];
    logic [BYTE_W-1:0] q;
    logic [BYTE_W-1:0] ch;
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind >= 8) begin
      repeat ($urandom_range(12)) push_byte(noise_byte(), 1'b0);
      push_byte(noise_byte(), 1'b1);
      return;
    end
    repeat ($urandom_range(8, 1)) begin
      case ($urandom_range(7))
        0: repeat ($urandom_range(3, 1)) push_byte(letter(), 1'b0);
        1: begin
          if (closers.size() < 6) begin
            case ($urandom_range(2))
              0: begin
                push_byte(CH_LPAREN, 1'b0);
                closers.push_back(CH_RPAREN);
              end
              1: begin
                push_byte(CH_LBRACK, 1'b0);
                closers.push_back(CH_RBRACK);
              end
              default: begin
                push_byte(CH_LBRACE, 1'b0);
                closers.push_back(CH_RBRACE);
              end
            endcase
          end
        end
        2: if (closers.size() != 0) push_byte(closers.pop_back(), 1'b0);
        3: begin
          q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
          push_byte(q, 1'b0);
          repeat ($urandom_range(4)) begin
            if ($urandom_range(3) == 0) begin
              push_byte(CH_BSLASH, 1'b0);
              push_byte(noise_byte(), 1'b0);
            end else begin
              ch = noise_byte();
              if (ch == q || ch == CH_BSLASH) ch = CH_SEMI;
              push_byte(ch, 1'b0);
            end
          end
          push_byte(q, 1'b0);
        end
        4: begin
          push_byte(CH_SLASH, 1'b0);
          push_byte(CH_SLASH, 1'b0);
          repeat ($urandom_range(4)) begin
            ch = noise_byte();
            if (ch == CH_LF || ch == CH_CR) ch = CH_RBRACE;
            push_byte(ch, 1'b0);
          end
          push_byte($urandom_range(1) ? CH_LF : CH_CR, 1'b0);
        end
        5: begin
          push_byte(CH_SLASH, 1'b0);
          push_byte(CH_STAR, 1'b0);
          repeat ($urandom_range(4)) begin
            ch = noise_byte();
            if (ch == CH_SLASH) ch = CH_STAR;
            push_byte(ch, 1'b0);
          end
          push_byte(CH_STAR, 1'b0);
          push_byte(CH_SLASH, 1'b0);
        end
        6: begin
          push_byte(CH_SLASH, 1'b0);
          push_byte(letter(), 1'b0);
        end
        default: push_byte(closers.size() != 0 ? CH_SEMI : letter(), 1'b0);
      endcase
    end
    while (closers.size() != 0) push_byte(closers.pop_back(), 1'b0);
    if (kind == 7) begin
      push_byte(letter(), 1'b1);
    end else begin
      ch = $urandom_range(1) ? CH_SEMI : CH_RBRACE;
      if ($urandom_range(2) == 0) begin
        push_byte(ch, 1'b1);
      end else begin
        push_byte(ch, 1'b0);
        repeat ($urandom_range(3)) push_byte(noise_byte(), 1'b0);
        push_byte(noise_byte(), 1'b1);
      end
    end
  endtask

  task automatic wait_idle();
    while (n_accepted != n_pushed || scan_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    scan_base = value;
    @(negedge clk_i);
  endtask

  task automatic random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                              input logic [BASE_W-1:0] base);
    int unsigned stop_at;
    write_base(base);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at = n_pushed + 110;
    while (n_pushed < stop_at) gen_scan();
    wait_idle();
  endtask

  initial begin
    src_idle_pct = 15;
    snk_idle_pct = 55;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    scan("", CH_SEMI);
    scan("", "a");
    scan("", CH_RBRACE);
    scan("", CH_SLASH);
    scan("", 8'hFF);
    scan("", 8'h00);
    scan("a = f(b;c)[d;e]{g;h}", CH_SEMI);
    scan(")]x;yy", "z");
    scan("x;y;", CH_SEMI);
    scan("a // ;}\n b", CH_SEMI);
    scan("c //;\015 d", CH_RBRACE);
    scan("/* ; } **/ e /*/ ; */", CH_SEMI);
    scan("s = \"a\\\";b\" + 'c;' + '\\'' ", CH_SEMI);
    scan("a / b /", CH_SEMI);
    scan("p/'", CH_SEMI);
    scan("\"abc;", "d");
    scan("'\\", CH_SQUOTE);
    scan("x //", CH_SEMI);
    scan("x /", CH_SLASH);
    wait_idle();

    write_base({BASE_W{1'b1}});
    scan("", CH_SEMI);
    scan("ab", "c");
    scan("{(}]);", "x");
    wait_idle();

    random_phase(15, 55, BASE_W'($urandom()));
    random_phase(55, 15, '0);
    random_phase(0, 0, BASE_W'($urandom()));

    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
